@@ rtl/core/swct_pkg.sv @@
package swct_pkg;

	localparam int WORD_LEN_DEF      = 30;
	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int COUNT_BITS_DEF    = 16;

	localparam int OP_W     = 2;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 6;
	localparam int STATUS_W = 3;
	localparam int OCOUNT_W = 16;

	localparam logic [OP_W-1:0] OP_CHAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NEW   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INC   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TRUNC = 3'd5;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

	// command broadcast along the cell row
	typedef struct packed {
		logic insert;   // shift/insert pass
		logic bump;     // increment the matching cell
	} swct_cmd_t;

endpackage

@@ rtl/core/swct_if.sv @@
interface swct_in_if;
	import swct_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [CHAR_W-1:0] text_char;
	logic [IDX_W-1:0]  read_index;
	modport source (output valid, op, text_char, read_index, input ready);
	modport sink   (input valid, op, text_char, read_index, output ready);
endinterface

interface swct_out_if;
	import swct_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] out_status;
	logic [CHAR_W-1:0]   out_char;
	logic [OCOUNT_W-1:0] out_count;
	logic                out_last;
	modport source (output valid, out_status, out_char, out_count, out_last, input ready);
	modport sink   (input valid, out_status, out_char, out_count, out_last, output ready);
endinterface

@@ rtl/core/swct_cell.sv @@
// One table slot: holds a word and its count, compares against the
// broadcast word and takes its left neighbour's contents on insertion.
module swct_cell #(
	parameter int WORD_LEN   = swct_pkg::WORD_LEN_DEF,
	parameter int COUNT_BITS = swct_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [WORD_LEN*8-1:0]         word,
	input  swct_pkg::swct_cmd_t           cmd,
	input  logic                          left_lt,   // neighbour below holds a smaller word
	input  logic                          left_used,
	input  logic [WORD_LEN*8-1:0]         left_chars,
	input  logic [COUNT_BITS-1:0]         left_count,
	output logic                          used,
	output logic                          lt,        // this entry < word
	output logic                          eq,
	output logic [WORD_LEN*8-1:0]         chars,
	output logic [COUNT_BITS-1:0]         count
);
	import swct_pkg::*;

	logic                  used_q;
	logic [WORD_LEN*8-1:0] chars_q;
	logic [COUNT_BITS-1:0] count_q;

	// big-endian packing: first character in the top byte, so plain compare works
	assign lt    = used_q && (chars_q < word);
	assign eq    = used_q && (chars_q == word);
	assign used  = used_q;
	assign chars = chars_q;
	assign count = count_q;

	// a slot becomes used when it takes the new word or a used neighbour's entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.insert && !lt) begin
			used_q <= used_q | left_used | left_lt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && !lt) begin
			if (left_lt) begin
				chars_q <= word;
				count_q <= COUNT_BITS'(1);
			end else begin
				chars_q <= left_chars;
				count_q <= left_count;
			end
		end else if (cmd.bump && eq && count_q != '1) begin
			count_q <= count_q + COUNT_BITS'(1);
		end
	end

endmodule

@@ rtl/core/sorted_word_count_table.sv @@
// Sorted word count table.
// Input channel (in_ch) carries op, text_char and read_index; output channel
// (out_ch) carries out_status, out_char, out_count and out_last.
// Text bytes are gathered into a word register, one byte per cycle while idle, no result.
// A space, zero byte or end-of-text op ends the word: the compare state checks the
// word against every slot of the cell row at once, then the update state either bumps the
// matching slot, shifts the larger entries up one cell and drops the word in, or leaves a
// full table unchanged. One result word follows from the output state.
// A read returns WORD_LEN result words, one per character, or one empty-slot
// word when the index is past the used entries.
// The output register drains one word per cycle while the receiver holds ready
// high. Reset empties the table and the word register at once.
// While the receiver holds ready low the output register keeps its word and
// no new item is taken until the run has been delivered.
module sorted_word_count_table #(
	parameter int WORD_LEN      = swct_pkg::WORD_LEN_DEF,
	parameter int TABLE_ENTRIES = swct_pkg::TABLE_ENTRIES_DEF,
	parameter int COUNT_BITS    = swct_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	swct_in_if.sink     in_ch,
	swct_out_if.source  out_ch
);
	import swct_pkg::*;

	localparam int LW = $clog2(WORD_LEN + 1);
	localparam int PW = $clog2(WORD_LEN);
	localparam int EW = $clog2(TABLE_ENTRIES + 1);
	localparam int TW = $clog2(TABLE_ENTRIES);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CMP  = 5'b00010,
		S_UPD  = 5'b00100,
		S_OUT  = 5'b01000,
		S_READ = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [WORD_LEN*8-1:0]  word_q;
	logic [LW-1:0]          len_q;
	logic                   ovf_q;
	logic [EW-1:0]          used_q;
	logic                   hit_s1, full_s1;
	logic [TW-1:0]          rd_idx_q;
	logic [PW-1:0]          pos_q;
	swct_cmd_t              cmd;

	logic [TABLE_ENTRIES-1:0]             c_used, c_lt, c_eq;
	logic [WORD_LEN*8-1:0]                c_chars [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0]                c_count [TABLE_ENTRIES];

	logic [STATUS_W-1:0]    st_q;
	logic [CHAR_W-1:0]      ch_q;
	logic [OCOUNT_W-1:0]    cnt_q;
	logic                   last_q;

	logic acc, ends, fire;
	logic [COUNT_BITS-1:0] hit_cnt;

	assign cmd.insert = (state_q == S_UPD) && !hit_s1 && !full_s1;
	assign cmd.bump   = (state_q == S_UPD) && hit_s1;

	// cell row
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		logic                  l_lt, l_used;
		logic [WORD_LEN*8-1:0] l_chars;
		logic [COUNT_BITS-1:0] l_count;
		if (i == 0) begin : g_first
			assign l_lt    = 1'b1;
			assign l_used  = 1'b0;
			assign l_chars = '0;
			assign l_count = '0;
		end else begin : g_rest
			assign l_lt    = c_lt[i-1];
			assign l_used  = c_used[i-1];
			assign l_chars = c_chars[i-1];
			assign l_count = c_count[i-1];
		end
		swct_cell #(.WORD_LEN(WORD_LEN), .COUNT_BITS(COUNT_BITS)) u_cell (
			.clk, .arst_n, .word(word_q), .cmd,
			.left_lt(l_lt), .left_used(l_used), .left_chars(l_chars), .left_count(l_count),
			.used(c_used[i]), .lt(c_lt[i]), .eq(c_eq[i]),
			.chars(c_chars[i]), .count(c_count[i])
		);
	end

	// one-hot hit to the count of the matching cell
	always_comb begin
		hit_cnt = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (c_eq[i]) hit_cnt = c_count[i];
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign acc  = in_ch.valid && in_ch.ready;
	assign ends = (in_ch.op == OP_FLUSH) ||
		((in_ch.op == OP_CHAR) && (in_ch.text_char == SPACE_CHAR || in_ch.text_char == '0));
	assign fire = out_ch.valid && out_ch.ready;

	assign out_ch.valid      = (state_q == S_OUT) || (state_q == S_READ);
	assign out_ch.out_status = st_q;
	assign out_ch.out_char   = ch_q;
	assign out_ch.out_count  = cnt_q;
	assign out_ch.out_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			word_q  <= '0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			used_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (acc) begin
					if (ends) begin
						if (len_q != '0) state_q <= S_CMP;
					end else if (in_ch.op == OP_CHAR) begin
						if (len_q < LW'(WORD_LEN)) begin
							word_q[(WORD_LEN*8-1) - 8*len_q -: 8] <= in_ch.text_char;
							len_q <= len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end else if (in_ch.op == OP_READ) begin
						state_q <= S_READ;
					end
				end
				S_CMP: state_q <= S_UPD;
				S_UPD: begin
					if (cmd.insert) used_q <= used_q + EW'(1);
					state_q <= S_OUT;
				end
				S_OUT: if (fire) begin
					state_q <= S_IDLE;
					word_q  <= '0;
					len_q   <= '0;
					ovf_q   <= 1'b0;
				end
				S_READ: if (fire && last_q) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// compare results, result word and read sequencing
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rd_idx_q <= in_ch.read_index[TW-1:0];
				pos_q    <= '0;
				ch_q     <= c_chars[in_ch.read_index[TW-1:0]][WORD_LEN*8-1 -: 8];
				cnt_q    <= OCOUNT_W'(c_count[in_ch.read_index[TW-1:0]]);
				st_q     <= ST_READ;
				last_q   <= (WORD_LEN == 1);
				if ({1'b0, in_ch.read_index} >= {1'b0, used_q}) begin
					st_q <= ST_EMPTY; ch_q <= '0; cnt_q <= '0; last_q <= 1'b1;
				end
			end
			S_CMP: begin
				hit_s1  <= |c_eq;
				full_s1 <= (used_q >= EW'(TABLE_ENTRIES));
			end
			S_UPD: begin
				ch_q   <= '0;
				last_q <= 1'b1;
				if (hit_s1) begin
					st_q  <= ovf_q ? ST_TRUNC : ST_INC;
					cnt_q <= OCOUNT_W'((hit_cnt == '1) ? hit_cnt : hit_cnt + COUNT_BITS'(1));
				end else if (full_s1) begin
					st_q <= ST_FULL; cnt_q <= '0;
				end else begin
					st_q <= ovf_q ? ST_TRUNC : ST_NEW; cnt_q <= OCOUNT_W'(1);
				end
			end
			S_READ: if (fire && !last_q) begin
				pos_q  <= pos_q + PW'(1);
				ch_q   <= c_chars[rd_idx_q][(WORD_LEN*8-1) - 8*(pos_q + PW'(1)) -: 8];
				last_q <= (pos_q + PW'(1) == PW'(WORD_LEN-1));
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/swct_checker.sv @@
module swct_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [2:0]             out_status,
	input logic [7:0]             out_char,
	input logic                   out_last
);
	import swct_pkg::*;

	// no new word taken while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during result run");

	// stalled result keeps its status and last flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_last))
		else $error("stalled result changed");

	// non-read results carry no character and end the run
	a_nonread: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_READ |-> out_char == '0 && out_last)
		else $error("bad non-read result");

	// after the last word of a run the block is ready again
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> in_ready && !out_valid)
		else $error("block not idle after run");

endmodule

bind sorted_word_count_table swct_checker u_swct_checker (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_status(out_ch.out_status), .out_char(out_ch.out_char),
	.out_last(out_ch.out_last)
);
